### hdl/bptc_pkg.sv
// Shared types, constants and sign helpers for the barometer compensation block.
// Used by bptc_mul, bptc_div and baro_temp_pressure_compensation; no dependencies.
package bptc_pkg;

	localparam int unsigned DW = 64;
	localparam int unsigned CW = 48;

	localparam logic [63:0] FINE_OFFSET = 64'd128000;
	localparam logic [63:0] DIV_SCALE   = 64'd3125;
	localparam logic [63:0] RAW_FULL    = 64'd1048576;

	localparam logic [1:0] REG_TEMP    = 2'd0;
	localparam logic [1:0] REG_PRESS_A = 2'd1;
	localparam logic [1:0] REG_PRESS_B = 2'd2;
	localparam logic [1:0] REG_PRESS_C = 2'd3;

	localparam logic OP_TEMP  = 1'b0;
	localparam logic OP_PRESS = 1'b1;

	typedef struct packed {
		logic        start;
		logic [63:0] a;
		logic [63:0] b;
	} unit_req_t;

	function automatic logic [63:0] sx16(input logic [15:0] v);
		sx16 = {{48{v[15]}}, v};
	endfunction

	function automatic logic [63:0] sx32(input logic [31:0] v);
		sx32 = {{32{v[31]}}, v};
	endfunction

endpackage

### hdl/bptc_mul.sv
// Bit-serial shift-add multiplier giving the low 64 bits of a 64 x 64 product.
// One multiplier bit per cycle. Depends on bptc_pkg.
module bptc_mul (
	input  logic                clk,
	input  logic                arst_n,
	input  bptc_pkg::unit_req_t req,
	output logic                done,
	output logic [63:0]         prod
);

	logic [63:0] acc_q;
	logic [63:0] ma_q;
	logic [63:0] mb_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			ma_q  <= req.a;
			mb_q  <= req.b;
		end else if (busy_q) begin
			if (mb_q[0]) begin
				acc_q <= acc_q + ma_q;
			end
			ma_q <= {ma_q[62:0], 1'b0};
			mb_q <= {1'b0, mb_q[63:1]};
		end
	end

	assign done = done_q;
	assign prod = acc_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("multiplier restarted while busy");
	a_done_ends: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("multiplier done while still busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("multiplier done held for two cycles");

endmodule

### hdl/bptc_div.sv
// Radix-2 restoring divider for signed 64-bit operands, quotient truncated toward zero.
// One quotient bit per cycle. Depends on bptc_pkg.
module bptc_div (
	input  logic                clk,
	input  logic                arst_n,
	input  bptc_pkg::unit_req_t req,
	output logic                done,
	output logic [63:0]         quo
);

	logic [63:0] rem_q;
	logic [63:0] quo_q;
	logic [63:0] dvs_q;
	logic        neg_q;
	logic [6:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [64:0] shifted;
	logic [64:0] trial;

	assign shifted = {rem_q, quo_q[63]};
	assign trial   = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= 7'd0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Magnitudes are divided; the most negative value keeps its pattern as 2^63.
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			quo_q <= req.a[63] ? (64'd0 - req.a) : req.a;
			dvs_q <= req.b[63] ? (64'd0 - req.b) : req.b;
			neg_q <= req.a[63] ^ req.b[63];
		end else if (busy_q) begin
			rem_q <= trial[64] ? shifted[63:0] : trial[63:0];
			quo_q <= {quo_q[62:0], ~trial[64]};
		end
	end

	assign done = done_q;
	assign quo  = neg_q ? (64'd0 - quo_q) : quo_q;

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> (req.b != 64'd0)) else $error("divider started with zero divisor");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("divider done held for two cycles");

endmodule

### hdl/baro_temp_pressure_compensation.sv
// Top level of the barometer compensation block: APB calibration registers,
// the step sequencer and the output register. Depends on bptc_pkg, bptc_mul, bptc_div.
//
// Usage. Calibration words are written over the APB port, one 48-bit register per
// 64-bit word at byte addresses 0, 8, 16 and 24. The user must write them only
// while the block is idle; the block itself does not enforce this. Items enter on
// in_valid/in_ready with opcode and raw_reading; each gives one result item on
// out_valid/out_ready carrying compensated and divisor_zero. An item is worked on
// by a sequencer that drives one shared bit-serial multiplier and one bit-serial
// divider. A temperature item needs three products; a pressure item needs ten
// products and one division, or only six products when the divisor is zero.
// in_ready is high only while the sequencer is idle, so one item is in work at
// a time; a finished result sits in the output register, and the next item is
// taken while it waits. If the receiver stalls with a result still held, the
// following result waits in the sequencer until the register frees.
// Reset clears the calibration registers, the stored fine temperature and all
// handshake state.
module baro_temp_pressure_compensation (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [19:0] raw_reading,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] compensated,
	output logic        divisor_zero
);

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_T0   = 5'd1;
	localparam logic [4:0] S_T1   = 5'd2;
	localparam logic [4:0] S_T2   = 5'd3;
	localparam logic [4:0] S_T3   = 5'd4;
	localparam logic [4:0] S_P0   = 5'd5;
	localparam logic [4:0] S_P1   = 5'd6;
	localparam logic [4:0] S_P2   = 5'd7;
	localparam logic [4:0] S_P3   = 5'd8;
	localparam logic [4:0] S_P4   = 5'd9;
	localparam logic [4:0] S_P5   = 5'd10;
	localparam logic [4:0] S_P6   = 5'd11;
	localparam logic [4:0] S_P7   = 5'd12;
	localparam logic [4:0] S_P8   = 5'd13;
	localparam logic [4:0] S_P9   = 5'd14;
	localparam logic [4:0] S_P10  = 5'd15;
	localparam logic [4:0] S_P11  = 5'd16;
	localparam logic [4:0] S_MW   = 5'd17;
	localparam logic [4:0] S_DW   = 5'd18;
	localparam logic [4:0] S_FIN  = 5'd19;

	logic [47:0] calib_temp_q, calib_press_a_q, calib_press_b_q, calib_press_c_q;
	logic [31:0] fine_q;
	logic [4:0]  state_q, ret_q;
	logic [19:0] adc_q;
	logic [63:0] a_q, b_q, x_q, p_q, q_q, t_q;
	logic [31:0] res_q;
	logic        zd_q;
	logic        out_valid_q;
	logic [31:0] compensated_q;
	logic        divisor_zero_q;
	logic        mul_start_q, div_start_q;
	logic [63:0] mul_a_q, mul_b_q, div_a_q, div_b_q;
	bptc_pkg::unit_req_t mul_req, div_req;
	logic        mul_done, div_done;
	logic [63:0] prod, quo;

	logic        wr_en;
	logic [63:0] d1_w, d2_w, a_w, a2_w, pnum_w, qv_w, t12_w, t14_w, x5_w, pres_w;
	logic [31:0] ft_w, tsum_w;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		case (paddr[4:3])
			bptc_pkg::REG_TEMP:    prdata = {16'd0, calib_temp_q};
			bptc_pkg::REG_PRESS_A: prdata = {16'd0, calib_press_a_q};
			bptc_pkg::REG_PRESS_B: prdata = {16'd0, calib_press_b_q};
			bptc_pkg::REG_PRESS_C: prdata = {16'd0, calib_press_c_q};
			default:               prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			calib_temp_q    <= '0;
			calib_press_a_q <= '0;
			calib_press_b_q <= '0;
			calib_press_c_q <= '0;
		end else if (wr_en) begin
			case (paddr[4:3])
				bptc_pkg::REG_TEMP:    calib_temp_q    <= pwdata[47:0];
				bptc_pkg::REG_PRESS_A: calib_press_a_q <= pwdata[47:0];
				bptc_pkg::REG_PRESS_B: calib_press_b_q <= pwdata[47:0];
				bptc_pkg::REG_PRESS_C: calib_press_c_q <= pwdata[47:0];
				default: ;
			endcase
		end
	end

	// Temperature terms are kept as sign-extended 32-bit values so that the
	// 64-bit arithmetic shifts behave as 32-bit ones.
	assign d1_w   = bptc_pkg::sx32(({12'd0, adc_q} >> 3) - {15'd0, calib_temp_q[15:0], 1'b0});
	assign d2_w   = bptc_pkg::sx32(({12'd0, adc_q} >> 4) - {16'd0, calib_temp_q[15:0]});
	assign t12_w  = 64'($signed(bptc_pkg::sx32(prod[31:0])) >>> 12);
	assign t14_w  = 64'($signed(bptc_pkg::sx32(prod[31:0])) >>> 14);
	assign ft_w   = x_q[31:0] + t14_w[31:0];
	assign tsum_w = {ft_w[29:0], 2'b00} + ft_w + 32'd128;

	assign a_w    = bptc_pkg::sx32(fine_q) - bptc_pkg::FINE_OFFSET;
	assign x5_w   = 64'd1 << 47;
	assign a2_w   = 64'($signed(prod) >>> 33);
	assign pnum_w = ((bptc_pkg::RAW_FULL - {44'd0, adc_q}) << 31) - b_q;
	assign qv_w   = 64'($signed(quo) >>> 13);
	assign pres_w = 64'($signed(p_q + x_q + 64'($signed(prod) >>> 19)) >>> 8)
		+ (bptc_pkg::sx16(calib_press_c_q[15:0]) << 4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= S_IDLE;
			fine_q      <= '0;
			out_valid_q <= 1'b0;
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
		end else begin
			mul_start_q <= 1'b0;
			div_start_q <= 1'b0;
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= (opcode == bptc_pkg::OP_PRESS) ? S_P0 : S_T0;
					end
				end
				S_T0: begin
					mul_start_q <= 1'b1;
					ret_q   <= S_T1;
					state_q <= S_MW;
				end
				S_T1: begin
					mul_start_q <= 1'b1;
					ret_q   <= S_T2;
					state_q <= S_MW;
				end
				S_T2: begin
					mul_start_q <= 1'b1;
					ret_q   <= S_T3;
					state_q <= S_MW;
				end
				S_T3: begin
					fine_q  <= ft_w;
					state_q <= S_FIN;
				end
				S_P0, S_P1, S_P2, S_P3, S_P4, S_P5, S_P8, S_P9, S_P10: begin
					mul_start_q <= 1'b1;
					ret_q   <= state_q + 5'd1;
					state_q <= S_MW;
				end
				S_P6: begin
					if (a2_w == 64'd0) begin
						state_q <= S_FIN;
					end else begin
						mul_start_q <= 1'b1;
						ret_q   <= S_P7;
						state_q <= S_MW;
					end
				end
				S_P7: begin
					div_start_q <= 1'b1;
					ret_q   <= S_P8;
					state_q <= S_DW;
				end
				S_P11: begin
					state_q <= S_FIN;
				end
				S_MW: begin
					if (mul_done) begin
						state_q <= ret_q;
					end
				end
				S_DW: begin
					if (div_done) begin
						state_q <= ret_q;
					end
				end
				S_FIN: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers and unit operands.
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: adc_q <= raw_reading;
			S_T0: begin
				mul_a_q <= d1_w;
				mul_b_q <= bptc_pkg::sx16(calib_temp_q[31:16]);
			end
			S_T1: begin
				x_q <= 64'($signed(bptc_pkg::sx32(prod[31:0])) >>> 11);
				mul_a_q <= d2_w;
				mul_b_q <= d2_w;
			end
			S_T2: begin
				mul_a_q <= t12_w;
				mul_b_q <= bptc_pkg::sx16(calib_temp_q[47:32]);
			end
			S_T3: begin
				res_q <= 32'($signed(tsum_w) >>> 8);
				zd_q  <= 1'b0;
			end
			S_P0: begin
				a_q <= a_w;
				mul_a_q <= a_w;
				mul_b_q <= a_w;
			end
			S_P1: begin
				t_q <= prod;
				mul_a_q <= prod;
				mul_b_q <= bptc_pkg::sx16(calib_press_b_q[47:32]);
			end
			S_P2: begin
				b_q <= prod;
				mul_a_q <= a_q;
				mul_b_q <= bptc_pkg::sx16(calib_press_b_q[31:16]);
			end
			S_P3: begin
				b_q <= b_q + (prod << 17) + (bptc_pkg::sx16(calib_press_b_q[15:0]) << 35);
				mul_a_q <= t_q;
				mul_b_q <= bptc_pkg::sx16(calib_press_a_q[47:32]);
			end
			S_P4: begin
				x_q <= 64'($signed(prod) >>> 8);
				mul_a_q <= a_q;
				mul_b_q <= bptc_pkg::sx16(calib_press_a_q[31:16]);
			end
			S_P5: begin
				mul_a_q <= x5_w + x_q + (prod << 12);
				mul_b_q <= {48'd0, calib_press_a_q[15:0]};
			end
			S_P6: begin
				a_q <= a2_w;
				res_q <= '0;
				zd_q  <= 1'b1;
				mul_a_q <= pnum_w;
				mul_b_q <= bptc_pkg::DIV_SCALE;
			end
			S_P7: begin
				div_a_q <= prod;
				div_b_q <= a_q;
			end
			S_P8: begin
				p_q <= quo;
				q_q <= qv_w;
				mul_a_q <= bptc_pkg::sx16(calib_press_c_q[47:32]);
				mul_b_q <= qv_w;
			end
			S_P9: begin
				mul_a_q <= prod;
				mul_b_q <= q_q;
			end
			S_P10: begin
				x_q <= 64'($signed(prod) >>> 25);
				mul_a_q <= bptc_pkg::sx16(calib_press_c_q[31:16]);
				mul_b_q <= p_q;
			end
			S_P11: begin
				res_q <= pres_w[31:0];
				zd_q  <= 1'b0;
			end
			S_FIN: begin
				if (!out_valid_q || out_ready) begin
					compensated_q  <= res_q;
					divisor_zero_q <= zd_q;
				end
			end
			default: ;
		endcase
	end

	assign mul_req = {mul_start_q, mul_a_q, mul_b_q};
	assign div_req = {div_start_q, div_a_q, div_b_q};

	bptc_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mul_req),
		.done   (mul_done),
		.prod   (prod)
	);

	bptc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.done   (div_done),
		.quo    (quo)
	);

	assign in_ready     = (state_q == S_IDLE);
	assign out_valid    = out_valid_q;
	assign compensated  = compensated_q;
	assign divisor_zero = divisor_zero_q;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("item taken but sequencer idle");
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_FIN)) else $error("result without finish");
	a_mul_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mul_start_q |-> (state_q == S_MW)) else $error("multiply started outside wait");
	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_start_q |-> (state_q == S_DW)) else $error("divide started outside wait");

endmodule

### test/tb_top.sv
// Self-checking testbench for baro_temp_pressure_compensation: calibration over APB,
// directed table then random items, results checked against a built-in compensation predictor.
// Depends on bptc_pkg and the block's RTL only.
module tb_top;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [4:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid, in_ready;
	logic        opcode;
	logic [19:0] raw_reading;
	logic        out_valid, out_ready;
	logic [31:0] compensated;
	logic        divisor_zero;

	typedef struct {
		logic [31:0] value;
		logic        zero_div;
	} comp_result_t;

	typedef struct {
		logic        op;
		logic [19:0] raw;
		logic        typed;
		logic [31:0] value;
		logic        zero_div;
	} stim_row_t;

	comp_result_t pending_q[$];
	logic [47:0]  cal_regs[4];
	logic [31:0]  fine_t;
	int           mismatches;
	bit           random_stall;
	bit           long_hold;

	baro_temp_pressure_compensation i_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_ready(in_ready),
		.opcode(opcode), .raw_reading(raw_reading),
		.out_valid(out_valid), .out_ready(out_ready),
		.compensated(compensated), .divisor_zero(divisor_zero)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#40000000;
		$display("** baro_temp_pressure_compensation: FAILED **");
		$finish;
	end

	function automatic logic signed [63:0] word_sx(input logic [47:0] r, input int pos);
		word_sx = signed'(bptc_pkg::sx16(r[pos +: 16]));
	endfunction

	function automatic comp_result_t compensate(input logic op, input logic [19:0] raw);
		comp_result_t res;
		logic [31:0] t1, t2, t3, d1, v1, d2, v2, tmp;
		logic signed [63:0] a, b, p, q, num, p1;
		logic [63:0] ma, mb, mq;
		res.zero_div = 1'b0;
		if (op == bptc_pkg::OP_TEMP) begin
			t1 = {16'd0, cal_regs[bptc_pkg::REG_TEMP][15:0]};
			t2 = bptc_pkg::sx32(bptc_pkg::sx16(cal_regs[bptc_pkg::REG_TEMP][31:16]));
			t3 = bptc_pkg::sx32(bptc_pkg::sx16(cal_regs[bptc_pkg::REG_TEMP][47:32]));
			d1 = {12'd0, raw} >> 3;
			d1 = d1 - (t1 << 1);
			v1 = 32'(signed'(d1 * t2) >>> 11);
			d2 = ({12'd0, raw} >> 4) - t1;
			tmp = 32'(signed'(d2 * d2) >>> 12);
			v2 = 32'(signed'(tmp * t3) >>> 14);
			fine_t = v1 + v2;
			tmp = fine_t * 32'd5 + 32'd128;
			res.value = 32'(signed'(tmp) >>> 8);
		end else begin
			p1 = {48'd0, cal_regs[bptc_pkg::REG_PRESS_A][15:0]};
			a = signed'(bptc_pkg::sx32(fine_t)) - signed'(bptc_pkg::FINE_OFFSET);
			b = a * a * word_sx(cal_regs[bptc_pkg::REG_PRESS_B], 32);
			b = b + ((a * word_sx(cal_regs[bptc_pkg::REG_PRESS_B], 16)) <<< 17);
			b = b + (word_sx(cal_regs[bptc_pkg::REG_PRESS_B], 0) <<< 35);
			a = ((a * a * word_sx(cal_regs[bptc_pkg::REG_PRESS_A], 32)) >>> 8)
				+ ((a * word_sx(cal_regs[bptc_pkg::REG_PRESS_A], 16)) <<< 12);
			a = ((64'sd1 <<< 47) + a) * p1 >>> 33;
			if (a == 0) begin
				res.value = '0;
				res.zero_div = 1'b1;
			end else begin
				p = signed'(bptc_pkg::RAW_FULL) - signed'({44'd0, raw});
				num = ((p <<< 31) - b) * signed'(bptc_pkg::DIV_SCALE);
				ma = num[63] ? -num : num;
				mb = a[63] ? -a : a;
				mq = ma / mb;
				p = (num[63] != a[63]) ? -mq : mq;
				q = p >>> 13;
				a = (word_sx(cal_regs[bptc_pkg::REG_PRESS_C], 32) * q * q) >>> 25;
				b = (word_sx(cal_regs[bptc_pkg::REG_PRESS_C], 16) * p) >>> 19;
				p = ((p + a + b) >>> 8) + (word_sx(cal_regs[bptc_pkg::REG_PRESS_C], 0) <<< 4);
				res.value = p[31:0];
			end
		end
		return res;
	endfunction

	task automatic apb_write(input logic [1:0] idx, input logic [47:0] val);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= {16'd0, val};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		cal_regs[idx] = val;
		@(posedge clk);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic send_item(input logic op, input logic [19:0] raw);
		if (random_stall && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		in_valid <= 1'b1;
		opcode <= op;
		raw_reading <= raw;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		pending_q.push_back(compensate(op, raw));
	endtask

	// Datasheet-like calibration with fixed values.
	task automatic load_typical();
		apb_write(bptc_pkg::REG_TEMP, {16'd50, 16'd26435, 16'd27504});
		apb_write(bptc_pkg::REG_PRESS_A, {16'hD0D0, 16'hD4BC, 16'd36477});
		apb_write(bptc_pkg::REG_PRESS_B, {16'hFFF9, 16'd140, 16'd2855});
		apb_write(bptc_pkg::REG_PRESS_C, {16'd6000, 16'hD82E, 16'd15500});
	endtask

	task automatic load_random();
		for (int r = 0; r < 4; r++)
			apb_write(r[1:0], {16'($urandom), 16'($urandom), 16'($urandom)});
	endtask

	// Receiver: random stalls, plus one long hold-off while the sender keeps going.
	initial begin
		out_ready = 1'b0;
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				out_ready <= 1'b0;
				repeat (3000) @(posedge clk);
				long_hold = 1'b0;
			end else if (random_stall && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 8)) @(posedge clk);
			end
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		comp_result_t exp_res;
		if (arst_n && out_valid && out_ready) begin
			if (pending_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result item %h", compensated);
			end else begin
				exp_res = pending_q.pop_front();
				if (compensated !== exp_res.value || divisor_zero !== exp_res.zero_div) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h/%b, got %h/%b", exp_res.value,
							exp_res.zero_div, compensated, divisor_zero);
				end
			end
		end
	end

	initial begin
		stim_row_t rows[$];
		comp_result_t got;
		int n;
		logic op;
		logic [19:0] raw;
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		in_valid = 1'b0; opcode = bptc_pkg::OP_TEMP; raw_reading = '0;
		mismatches = 0; random_stall = 1'b0; long_hold = 1'b0;
		for (int r = 0; r < 4; r++) cal_regs[r] = '0;
		fine_t = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// After reset every calibration word is zero, so each pressure divisor is zero.
		rows.push_back('{bptc_pkg::OP_TEMP, 20'd0, 1'b1, 32'd0, 1'b0});
		rows.push_back('{bptc_pkg::OP_PRESS, 20'd0, 1'b1, 32'd0, 1'b1});
		rows.push_back('{bptc_pkg::OP_PRESS, 20'hFFFFF, 1'b1, 32'd0, 1'b1});
		rows.push_back('{bptc_pkg::OP_TEMP, 20'hFFFFF, 1'b1, 32'd0, 1'b0});
		foreach (rows[i]) begin
			got = compensate(rows[i].op, rows[i].raw);
			if (got.value !== rows[i].value || got.zero_div !== rows[i].zero_div) begin
				mismatches++;
				if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
			end
			send_item(rows[i].op, rows[i].raw);
		end
		wait_idle();

		load_typical();
		for (int i = 0; i < 12; i++)
			send_item(i[0], (i < 4) ? (i[1] ? 20'hFFFFF : 20'd0) : 20'($urandom));
		wait_idle();

		// Extreme calibration words: full and most negative values wrap silently.
		apb_write(bptc_pkg::REG_TEMP, 48'hFFFF_FFFF_FFFF);
		apb_write(bptc_pkg::REG_PRESS_A, 48'h8000_8000_FFFF);
		apb_write(bptc_pkg::REG_PRESS_B, 48'h7FFF_7FFF_8000);
		apb_write(bptc_pkg::REG_PRESS_C, 48'h8000_7FFF_FFFF);
		for (int i = 0; i < 6; i++) send_item(i[0], i[1] ? 20'hFFFFF : 20'd0);
		wait_idle();

		random_stall = 1'b1;
		for (int ph = 0; ph < 6; ph++) begin
			if (ph == 0 || ph == 5) load_typical();
			else if (ph == 3) apb_write(bptc_pkg::REG_PRESS_A, 48'h0000_0000_0000);
			else load_random();
			if (ph == 2) long_hold = 1'b1;
			if (ph == 5) random_stall = 1'b0;
			n = 95;
			for (int i = 0; i < n; i++) begin
				op = ($urandom_range(0, 2) == 0) ? bptc_pkg::OP_TEMP : bptc_pkg::OP_PRESS;
				raw = ($urandom_range(0, 9) == 0) ? 20'($urandom)
					: 20'($urandom_range(300000, 700000));
				send_item(op, raw);
			end
			wait_idle();
		end

		if (mismatches == 0)
			$display("** baro_temp_pressure_compensation: PASSED **");
		else
			$display("** baro_temp_pressure_compensation: FAILED **");
		$finish;
	end

endmodule

### filelist.f
hdl/bptc_pkg.sv
hdl/bptc_mul.sv
hdl/bptc_div.sv
hdl/baro_temp_pressure_compensation.sv
test/tb_top.sv
